// ----- design/smoothed_target_rate_limiter_macros.svh -----
`ifndef SMOOTHED_TARGET_RATE_LIMITER_MACROS_SVH
`define SMOOTHED_TARGET_RATE_LIMITER_MACROS_SVH

`ifndef SYNTHESIS
`define STRL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("strl assertion failed");
`define STRL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("strl assertion failed");
`else
`define STRL_ASSERT_NOW(lbl, ante, cons)
`define STRL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/strl_pkg.sv -----
package strl_pkg;

  localparam int unsigned LEVEL_W = 32;
  localparam int unsigned GAIN_W  = 17;
  localparam int unsigned LIM_W   = 31;
  localparam int unsigned APB_W   = 32;
  localparam int unsigned ADDR_W  = 5;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd65536;
  localparam logic [LIM_W-1:0]  LIM_RESET  = 31'd65536;

  typedef enum logic [2:0] {
    REG_FILTER_GAIN = 3'd0,
    REG_GAIN_AWAY   = 3'd1,
    REG_GAIN_BACK   = 3'd2,
    REG_RISE_LIMIT  = 3'd3,
    REG_FALL_LIMIT  = 3'd4
  } reg_idx_t;

endpackage

// ----- design/strl_if.sv -----
interface strl_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic signed [strl_pkg::LEVEL_W-1:0]  level;

  modport source (output valid, output action, output level, input ready);
  modport sink (input valid, input action, input level, output ready);
endinterface

interface strl_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [strl_pkg::LEVEL_W-1:0]  smoothed;

  modport source (output valid, output smoothed, input ready);
  modport sink (input valid, input smoothed, output ready);
endinterface

// ----- design/smoothed_target_rate_limiter.sv -----
// Smoothed target rate limiter, signed Q16.16, gains unsigned Q1.16. An update
// transaction low-pass filters its target, derives a delta and a smoothed step
// from it and moves the output by that step, limited to rise_limit or
// fall_limit; a reset transaction loads the output and clears filter and step.
// Each transaction gives one result. An update makes three passes through one
// shared 18x33 multiplier, each a multiply state and an accumulate state, then
// takes the output state; a reset goes straight to the output state. The next
// transaction is accepted while a result still waits; the block then holds in
// its output state until the waiting result is taken.
`include "smoothed_target_rate_limiter_macros.svh"

module smoothed_target_rate_limiter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [strl_pkg::ADDR_W-1:0]   paddr,
  input  logic [strl_pkg::APB_W-1:0]    pwdata,
  output logic [strl_pkg::APB_W-1:0]    prdata,
  output logic                          pready,
  strl_req_if.sink                      req,
  strl_rsp_if.source                    rsp
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LP_MUL = 8'b0000_0010,
    ST_LP_ACC = 8'b0000_0100,
    ST_DL_MUL = 8'b0000_1000,
    ST_DL_ACC = 8'b0001_0000,
    ST_ST_MUL = 8'b0010_0000,
    ST_ST_ACC = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    logic signed [31:0] r;
    if (x > 36'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -36'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [31:0] x);
    logic [32:0] ext;
    ext = {x[31], x};
    return x[31] ? 33'(-ext) : ext;
  endfunction

  state_t state, state_next;

  logic [strl_pkg::GAIN_W-1:0] filter_gain, gain_away, gain_back;
  logic [strl_pkg::LIM_W-1:0]  rise_limit, fall_limit;

  logic signed [31:0] lowpass, step, outval, delta, level_r, smoothed;
  logic               act_r, res_valid;

  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] prod, prod_rnd;
  logic signed [34:0] rnd;
  logic signed [35:0] rnd_ext;

  logic        accept, out_free, cfg_wr;
  logic        take_gain, same_side, use_fall;
  logic [32:0] step_mag, move_mag;
  logic [30:0] limit;
  logic signed [33:0] move;
  logic signed [31:0] out_new;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_gain <= strl_pkg::GAIN_RESET;
      gain_away   <= strl_pkg::GAIN_RESET;
      gain_back   <= strl_pkg::GAIN_RESET;
      rise_limit  <= strl_pkg::LIM_RESET;
      fall_limit  <= strl_pkg::LIM_RESET;
    end else if (cfg_wr) begin
      case (strl_pkg::reg_idx_t'(paddr[4:2]))
        strl_pkg::REG_FILTER_GAIN: filter_gain <= pwdata[16:0];
        strl_pkg::REG_GAIN_AWAY:   gain_away   <= pwdata[16:0];
        strl_pkg::REG_GAIN_BACK:   gain_back   <= pwdata[16:0];
        strl_pkg::REG_RISE_LIMIT:  rise_limit  <= pwdata[30:0];
        strl_pkg::REG_FALL_LIMIT:  fall_limit  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (strl_pkg::reg_idx_t'(paddr[4:2]))
      strl_pkg::REG_FILTER_GAIN: prdata = {15'd0, filter_gain};
      strl_pkg::REG_GAIN_AWAY:   prdata = {15'd0, gain_away};
      strl_pkg::REG_GAIN_BACK:   prdata = {15'd0, gain_back};
      strl_pkg::REG_RISE_LIMIT:  prdata = {1'b0, rise_limit};
      strl_pkg::REG_FALL_LIMIT:  prdata = {1'b0, fall_limit};
      default:                   prdata = '0;
    endcase
  end

  // handshakes
  assign req.ready    = (state == ST_IDLE);
  assign accept       = req.valid && req.ready;
  assign out_free     = !res_valid || rsp.ready;
  assign rsp.valid    = res_valid;
  assign rsp.smoothed = smoothed;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (req.valid) state_next = req.action ? ST_OUT : ST_LP_MUL;
      ST_LP_MUL: state_next = ST_LP_ACC;
      ST_LP_ACC: state_next = ST_DL_MUL;
      ST_DL_MUL: state_next = ST_DL_ACC;
      ST_DL_ACC: state_next = ST_ST_MUL;
      ST_ST_MUL: state_next = ST_ST_ACC;
      ST_ST_ACC: state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = $signed({1'b0, filter_gain});
    mul_b = {level_r[31], level_r} - {lowpass[31], lowpass};
    case (state)
      ST_DL_MUL: begin
        mul_b = {lowpass[31], lowpass} - {outval[31], outval};
      end
      ST_ST_MUL: begin
        mul_a = (outval[31] == delta[31]) ? $signed({1'b0, gain_away})
                                          : $signed({1'b0, gain_back});
        mul_b = {delta[31], delta} - {step[31], step};
      end
      default: ;
    endcase
  end

  // round to nearest, tie toward plus infinity
  assign prod_rnd = prod + 51'sd32768;
  assign rnd      = $signed(prod_rnd[50:16]);
  assign rnd_ext  = {rnd[34], rnd};

  assign step_mag  = mag33(step);
  assign take_gain = (mag33(delta) > step_mag) || (delta[31] != step[31]);

  // output move
  assign same_side = (!outval[31] && !level_r[31]) ||
                     ((outval[31] || outval == 32'sd0) && (level_r[31] || level_r == 32'sd0));
  assign use_fall  = same_side && (mag33(outval) > mag33(level_r));
  assign limit     = use_fall ? fall_limit : rise_limit;
  assign move_mag  = (step_mag > {2'b00, limit}) ? {2'b00, limit} : step_mag;
  assign move      = step[31] ? 34'(-$signed({1'b0, move_mag})) : $signed({1'b0, move_mag});
  assign out_new   = act_r ? level_r
                           : sat32({{4{outval[31]}}, outval} + {{2{move[33]}}, move});

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= req.action;
      level_r <= req.level;
    end
    if (state == ST_LP_MUL || state == ST_DL_MUL || state == ST_ST_MUL) begin
      prod <= mul_a * mul_b;
    end
    if (state == ST_DL_ACC) begin
      delta <= sat32(rnd_ext);
    end
    if (state == ST_OUT && out_free) begin
      smoothed <= out_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowpass   <= '0;
      step      <= '0;
      outval    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (state == ST_LP_ACC) begin
        lowpass <= sat32({{4{lowpass[31]}}, lowpass} + rnd_ext);
      end
      if (state == ST_ST_ACC) begin
        step <= take_gain ? sat32({{4{step[31]}}, step} + rnd_ext) : delta;
      end
      if (state == ST_OUT && out_free) begin
        outval    <= out_new;
        res_valid <= 1'b1;
        if (act_r) begin
          lowpass <= '0;
          step    <= '0;
        end
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // checks
  `STRL_ASSERT_NEXT(a_accept_start, accept, state == ST_LP_MUL || state == ST_OUT)
  `STRL_ASSERT_NEXT(a_reset_clears, state == ST_OUT && out_free && act_r,
                    lowpass == 32'sd0 && step == 32'sd0 && rsp.smoothed == level_r)
  `STRL_ASSERT_NOW(a_result_from_out, $rose(rsp.valid), $past(state == ST_OUT))

endmodule
